@@ rtl/core/annexb_nal_unit_splitter_core_assert.svh @@
// Assertion macros for the NAL unit splitter core.
// Each macro has a checking form for simulation and an empty form for synthesis.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_CORE_ASSERT_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define ANBS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("anbs assertion failed");

// Property checked at every clock edge, reset included.
`define ANBS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("anbs assertion failed");

`else

`define ANBS_ASSERT(lbl, clk, rst_n, prop)
`define ANBS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/core/anbs_pkg.sv @@
package anbs_pkg;

    // Most results one input byte can cause: one shifted out, three flushed.
    localparam int BURST_MAX = 4;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    typedef struct packed {
        logic [7:0] unit_byte;
        logic       first_of_unit;
        logic       last_of_unit;
        logic [4:0] unit_type;
        logic [1:0] reference_priority;
    } t_result;

    // Results produced for one input byte, packed from slot 0 upward.
    typedef struct packed {
        logic [2:0]              count;
        t_result [BURST_MAX-1:0] item;
    } t_burst;

    typedef struct packed {
        logic [2:0] count;
        logic       take;
    } t_buf_status;

    function automatic t_result make_result(
        input logic [7:0] unit_byte,
        input logic       first,
        input logic       last,
        input logic [4:0] unit_type,
        input logic [1:0] prio
    );
        t_result r;
        r.unit_byte          = unit_byte;
        r.first_of_unit      = first;
        r.last_of_unit       = last;
        r.unit_type          = unit_type;
        r.reference_priority = prio;
        return r;
    endfunction

endpackage

@@ rtl/core/anbs_parse.sv @@
module anbs_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_stream,
    output anbs_pkg::t_burst  o_burst
);

    logic       r_inside,     n_inside;
    logic [1:0] r_zero_run,   n_zero_run;
    logic [1:0] r_held_count, n_held_count;
    logic       r_oldest_hdr, n_oldest_hdr;
    logic [4:0] r_type,       n_type;
    logic [1:0] r_prio,       n_prio;
    logic [7:0] r_held [0:2];
    logic [7:0] n_held [0:2];

    logic       norm;
    logic [1:0] slot;
    logic [1:0] flush_cnt;
    anbs_pkg::t_burst burst;

    always_comb begin
        n_inside     = r_inside;
        n_zero_run   = r_zero_run;
        n_held_count = r_held_count;
        n_oldest_hdr = r_oldest_hdr;
        n_type       = r_type;
        n_prio       = r_prio;
        n_held       = r_held;
        norm         = 1'b0;
        slot         = 2'd0;
        flush_cnt    = 2'd0;
        burst        = '0;

        if (!r_inside) begin
            // Search: count zeros, open a unit on 01 after two or more zeros.
            if (i_data_byte == anbs_pkg::BYTE_ZERO) begin
                if (r_zero_run != 2'd3) begin
                    n_zero_run = r_zero_run + 2'd1;
                end
            end else if (i_data_byte == anbs_pkg::BYTE_ONE && r_zero_run >= 2'd2) begin
                n_inside     = 1'b1;
                n_held_count = 2'd0;
                n_oldest_hdr = 1'b0;
                n_zero_run   = 2'd0;
            end else begin
                n_zero_run = 2'd0;
            end
        end else if (r_held_count == 2'd0) begin
            // Header byte: latch type and priority.
            n_type       = i_data_byte[4:0];
            n_prio       = i_data_byte[6:5];
            n_held[0]    = i_data_byte;
            n_held_count = 2'd1;
            n_oldest_hdr = 1'b1;
        end else if (r_held_count != 2'd3) begin
            n_held[r_held_count] = i_data_byte;
            n_held_count         = r_held_count + 2'd1;
        end else if (r_held[1] == anbs_pkg::BYTE_ZERO && r_held[2] == anbs_pkg::BYTE_ZERO
                     && i_data_byte <= anbs_pkg::BYTE_ONE) begin
            // Closing window: the oldest held byte ends the unit.
            norm          = 1'b1;
            burst.item[0] = anbs_pkg::make_result(r_held[0], r_oldest_hdr, 1'b1,
                                                  r_type, r_prio);
            n_held_count  = 2'd0;
            n_oldest_hdr  = 1'b0;
            if (i_data_byte == anbs_pkg::BYTE_ONE) begin
                n_inside   = 1'b1;
                n_zero_run = 2'd0;
            end else begin
                n_inside   = 1'b0;
                n_zero_run = 2'd3;
            end
        end else begin
            norm          = 1'b1;
            burst.item[0] = anbs_pkg::make_result(r_held[0], r_oldest_hdr, 1'b0,
                                                  r_type, r_prio);
            n_held[0]     = r_held[1];
            n_held[1]     = r_held[2];
            n_held[2]     = i_data_byte;
            n_oldest_hdr  = 1'b0;
        end

        burst.count = {2'b00, norm};

        if (i_end_of_stream) begin
            // Flush every held byte of an open unit, then restart the search.
            if (n_inside) begin
                flush_cnt = n_held_count;
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < flush_cnt) begin
                        slot = 2'(i) + {1'b0, norm};
                        burst.item[slot] = anbs_pkg::make_result(
                            n_held[i], (i == 0) && n_oldest_hdr,
                            (2'(i) + 2'd1) == flush_cnt, n_type, n_prio);
                    end
                end
                burst.count = {2'b00, norm} + {1'b0, flush_cnt};
            end
            n_inside     = 1'b0;
            n_zero_run   = 2'd0;
            n_held_count = 2'd0;
            n_oldest_hdr = 1'b0;
        end
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside     <= 1'b0;
            r_zero_run   <= 2'd0;
            r_held_count <= 2'd0;
            r_oldest_hdr <= 1'b0;
            r_type       <= 5'd0;
            r_prio       <= 2'd0;
        end else if (i_go) begin
            r_inside     <= n_inside;
            r_zero_run   <= n_zero_run;
            r_held_count <= n_held_count;
            r_oldest_hdr <= n_oldest_hdr;
            r_type       <= n_type;
            r_prio       <= n_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_held <= n_held;
        end
    end

endmodule

@@ rtl/core/anbs_rbuf.sv @@
module anbs_rbuf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_offer,
    input  anbs_pkg::t_burst       i_burst,
    input  logic                   i_stall,
    output anbs_pkg::t_buf_status  o_status,
    output logic                   o_valid,
    output anbs_pkg::t_result      o_result
);

    logic [2:0]        r_count, n_count;
    anbs_pkg::t_result r_slot [0:anbs_pkg::BURST_MAX-1];
    anbs_pkg::t_result n_slot [0:anbs_pkg::BURST_MAX-1];

    logic       pop;
    logic       take;
    logic [2:0] cnt_after;
    logic [2:0] k;

    always_comb begin
        n_slot    = r_slot;
        k         = 3'd0;
        pop       = (r_count != 3'd0) && !i_stall;
        cnt_after = r_count - {2'b00, pop};
        // Take the whole burst only when every result fits.
        take      = i_offer && (({1'b0, cnt_after} + {1'b0, i_burst.count})
                                <= 4'(anbs_pkg::BURST_MAX));
        n_count   = cnt_after + (take ? i_burst.count : 3'd0);
        for (int j = 0; j < anbs_pkg::BURST_MAX; j++) begin
            k = 3'(j) - cnt_after;
            if (3'(j) < cnt_after) begin
                n_slot[j] = pop ? r_slot[2'(j + 1)] : r_slot[j];
            end else if (take && k < i_burst.count) begin
                n_slot[j] = i_burst.item[k[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_status.count = r_count;
    assign o_status.take  = take;
    assign o_valid        = (r_count != 3'd0);
    assign o_result       = r_slot[0];

endmodule

@@ rtl/core/annexb_nal_unit_splitter_core.sv @@
// H.264 Annex B NAL unit splitter. Feed the byte stream one byte per transfer on
// i_data_byte, with i_end_of_stream on the final byte; every NAL unit comes out
// byte by byte, header byte included, with o_first_of_unit on the header, o_last_of_unit
// on its final byte, and the header's type and reference priority on every byte. Start
// codes (two or more zeros then 01) are dropped; a unit ends before the next
// 00 00 00 or 00 00 01 window, and emulation-prevention bytes pass through
// untouched. Three bytes of a unit are held back so a closing window is seen
// before the byte ahead of it is released, so output lags input by three bytes
// inside a unit. One byte is taken per cycle while i_stall is low: an input
// register feeds the parse logic, whose results drop into a four-slot result
// buffer drained one result per cycle while i_stall is low. The end-of-stream
// byte can release up to four results at once and is held in the input
// register until the buffer has room for all of them; otherwise throughput is
// one byte per cycle. A byte passes the input register and the result buffer
// before its first result shows. Up to two trailing zeros at the end of the stream
// stay part of the last unit, and a start code as the very last bytes yields nothing.
module annexb_nal_unit_splitter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_unit_byte,
    output logic       o_first_of_unit,
    output logic       o_last_of_unit,
    output logic [4:0] o_unit_type,
    output logic [1:0] o_reference_priority
);

`include "annexb_nal_unit_splitter_core_assert.svh"

    // Input register: holds one byte until its results fit in the buffer.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;

    anbs_pkg::t_burst      w_burst;
    anbs_pkg::t_buf_status w_status;
    anbs_pkg::t_result     w_result;
    logic                  w_accept;

    // Stall upstream only while the held byte cannot advance.
    assign o_stall  = r_in_valid && !w_status.take;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_status.take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    // Parse state advances only when the buffer takes this byte's results.
    anbs_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (w_status.take),
        .i_data_byte     (r_in_byte),
        .i_end_of_stream (r_in_eos),
        .o_burst         (w_burst)
    );

    anbs_rbuf u_rbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_offer  (r_in_valid),
        .i_burst  (w_burst),
        .i_stall  (i_stall),
        .o_status (w_status),
        .o_valid  (o_valid),
        .o_result (w_result)
    );

    assign o_unit_byte          = w_result.unit_byte;
    assign o_first_of_unit      = w_result.first_of_unit;
    assign o_last_of_unit       = w_result.last_of_unit;
    assign o_unit_type          = w_result.unit_type;
    assign o_reference_priority = w_result.reference_priority;

    // Result buffer never holds more than its four slots.
    `ANBS_ASSERT(a_buf_bound, i_clk, i_rst_n, w_status.count <= 3'd4)

    // A taken burst with results makes a result visible next cycle.
    `ANBS_ASSERT(a_burst_shows, i_clk, i_rst_n,
                 (w_status.take && w_burst.count != 3'd0) |=> o_valid)

    // A held byte that does not advance stays in the input register unchanged.
    `ANBS_ASSERT(a_in_hold, i_clk, i_rst_n,
                 (r_in_valid && !w_status.take) |=>
                 (r_in_valid && $stable(r_in_byte) && $stable(r_in_eos)))

    // Nothing is taken from an empty input register.
    `ANBS_ASSERT_ALWAYS(a_take_needs_byte, i_clk, w_status.take |-> r_in_valid)

endmodule
